FILE: rtl/mf3_pkg.sv
// shared types and constants of the 3x3 median filter
package mf3_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = 16;
	localparam int PIX_W     = 8;
	localparam int FW_W      = 11;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [FW_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd480;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [2:0]       pix3_t;

	// window entry r*3+c: row r (0 oldest line), column c (2 newest)
	typedef struct packed {
		pix_t [8:0]       win;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} item_t;

endpackage

FILE: rtl/mf3_ram.sv
// generic single write port, single read port ram with registered read
module mf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/mf3_front.sv
// front end: pixel counters, line stores, window and interior classification
module mf3_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [mf3_pkg::PIX_W-1:0]   pixel,
	input  logic                        pixel_valid,
	output logic                        pixel_stall,
	input  logic [mf3_pkg::FW_W-1:0]    frame_width,
	input  logic [mf3_pkg::ROW_W-1:0]   frame_height,
	input  logic [mf3_pkg::QCNT_W-1:0]  q_count,
	output logic                        push,
	output mf3_pkg::item_t              push_item
);
	import mf3_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             accept;
	logic [FW_W-1:0]  w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [FW_W-1:0]  col_ext;
	logic             col_wrap;
	logic             row_wrap;
	logic             emit;
	logic             last;
	logic [QCNT_W:0]  occupancy;

	logic             valid_s1;
	pix_t             pix_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             emit_s1;
	logic             last_s1;

	pix_t             up_rd;
	pix_t             mid_rd;
	pix_t [8:0]       win_q;
	pix_t [8:0]       win_next;

	// room for the item in flight as well as the queued ones
	assign occupancy   = {1'b0, q_count} + {{QCNT_W{1'b0}}, valid_s1};
	assign pixel_stall = occupancy >= (QCNT_W + 1)'(QDEPTH);
	assign accept      = pixel_valid && !pixel_stall;

	always_comb begin
		w_eff = frame_width;
		if (frame_width < FW_W'(3)) begin
			w_eff = FW_W'(3);
		end else if (frame_width > FW_W'(MAX_WIDTH)) begin
			w_eff = FW_W'(MAX_WIDTH);
		end
		h_eff = (frame_height < ROW_W'(3)) ? ROW_W'(3) : frame_height;
	end

	assign col_ext  = FW_W'(col_q);
	assign col_wrap = (col_ext + FW_W'(1)) >= w_eff;
	assign row_wrap = ({1'b0, row_q} + (ROW_W + 1)'(1)) >= {1'b0, h_eff};
	assign emit     = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2))
		&& (col_ext < w_eff) && (row_q < h_eff);
	assign last     = (col_ext == w_eff - FW_W'(1)) && (row_q == h_eff - ROW_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel;
			col_s1  <= col_q;
			row_s1  <= row_q;
			emit_s1 <= emit;
			last_s1 <= last;
		end
	end

	mf3_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_mid (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (pixel),
		.re    (accept),
		.raddr (col_q),
		.rdata (mid_rd)
	);

	// the middle line moves up in the cycle after its read
	mf3_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_up (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (mid_rd),
		.re    (accept),
		.raddr (col_q),
		.rdata (up_rd)
	);

	always_comb begin
		win_next    = win_q;
		win_next[0] = win_q[1];
		win_next[1] = win_q[2];
		win_next[3] = win_q[4];
		win_next[4] = win_q[5];
		win_next[6] = win_q[7];
		win_next[7] = win_q[8];
		win_next[2] = up_rd;
		win_next[5] = mid_rd;
		win_next[8] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (valid_s1) begin
			win_q <= win_next;
		end
	end

	assign push           = valid_s1 && emit_s1;
	assign push_item.win  = win_next;
	assign push_item.col  = col_s1 - COL_W'(1);
	assign push_item.row  = row_s1 - ROW_W'(1);
	assign push_item.last = last_s1;

endmodule

FILE: rtl/mf3_queue.sv
// short queue of classified windows between front and back
module mf3_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  mf3_pkg::item_t             push_item,
	input  logic                       pop,
	output logic                       head_valid,
	output mf3_pkg::item_t             head_item,
	output logic [mf3_pkg::QCNT_W-1:0] count
);
	import mf3_pkg::*;

	item_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	assign head_valid = count_q != '0;
	assign head_item  = slot_q[rd_ptr_q];
	assign count      = count_q;

endmodule

FILE: rtl/mf3_back.sv
// back end: pipelined median-of-nine network and output register
module mf3_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  mf3_pkg::item_t             head_item,
	output logic                       pop,
	output logic [mf3_pkg::PIX_W-1:0]  median,
	output logic [mf3_pkg::COL_W-1:0]  center_col,
	output logic [mf3_pkg::ROW_W-1:0]  center_row,
	output logic                       frame_last,
	output logic                       result_valid,
	input  logic                       result_stall
);
	import mf3_pkg::*;

	function automatic pix3_t sort3(pix_t a, pix_t b, pix_t c);
		pix_t x;
		pix_t y;
		pix_t z;
		pix_t t;
		x = a;
		y = b;
		z = c;
		if (x > y) begin
			t = x; x = y; y = t;
		end
		if (y > z) begin
			t = y; y = z; z = t;
		end
		if (x > y) begin
			t = x; x = y; y = t;
		end
		return {z, y, x};
	endfunction

	logic             advance;

	logic             valid_s1;
	pix3_t [2:0]      rows_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             last_s1;

	logic             valid_s2;
	pix_t             lo_s2;
	pix_t             md_s2;
	pix_t             hi_s2;
	logic [COL_W-1:0] col_s2;
	logic [ROW_W-1:0] row_s2;
	logic             last_s2;

	pix3_t            los;
	pix3_t            mds;
	pix3_t            his;
	pix3_t            fin;

	logic             valid_q;
	pix_t             median_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             last_q;

	assign advance = !(valid_q && result_stall);
	assign pop     = advance && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (advance) begin
			valid_s1 <= head_valid;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

	// sort each line of the window
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int r = 0; r < 3; r++) begin
				rows_s1[r] <= sort3(head_item.win[r*3], head_item.win[r*3+1],
					head_item.win[r*3+2]);
			end
			col_s1  <= head_item.col;
			row_s1  <= head_item.row;
			last_s1 <= head_item.last;
		end
	end

	// max of minima, median of medians, min of maxima
	assign los = sort3(rows_s1[0][0], rows_s1[1][0], rows_s1[2][0]);
	assign mds = sort3(rows_s1[0][1], rows_s1[1][1], rows_s1[2][1]);
	assign his = sort3(rows_s1[0][2], rows_s1[1][2], rows_s1[2][2]);

	always_ff @(posedge clk) begin
		if (advance) begin
			lo_s2   <= los[2];
			md_s2   <= mds[1];
			hi_s2   <= his[0];
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			last_s2 <= last_s1;
		end
	end

	assign fin = sort3(lo_s2, md_s2, hi_s2);

	always_ff @(posedge clk) begin
		if (advance) begin
			median_q <= fin[1];
			col_q    <= col_s2;
			row_q    <= row_s2;
			last_q   <= last_s2;
		end
	end

	assign result_valid = valid_q;
	assign median       = median_q;
	assign center_col   = col_q;
	assign center_row   = row_q;
	assign frame_last   = last_q;

endmodule

FILE: rtl/median_filter_3x3.sv
// top level of the streaming 3x3 median filter with its register port
// a result passes the front register, the queue and the median network after the transfer of its lower-right pixel
// throughput: one pixel per cycle while pixel_stall is low, set by one line store read and write per pixel
// the median network is a 3-stage pipeline behind a 4-entry queue
// reset clears counters, window and queue; line stores are not cleared
// registers reset to a 640 by 480 frame
module median_filter_3x3 (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mf3_pkg::ADDR_W-1:0]       paddr,
	input  logic [mf3_pkg::DATA_W-1:0]       pwdata,
	output logic [mf3_pkg::DATA_W-1:0]       prdata,
	output logic                             pready,
	input  logic [mf3_pkg::PIX_W-1:0]        pixel,
	input  logic                             pixel_valid,
	output logic                             pixel_stall,
	output logic [mf3_pkg::PIX_W-1:0]        median,
	output logic [mf3_pkg::COL_W-1:0]        center_col,
	output logic [mf3_pkg::ROW_W-1:0]        center_row,
	output logic                             frame_last,
	output logic                             result_valid,
	input  logic                             result_stall
);
	import mf3_pkg::*;

	logic [FW_W-1:0]   frame_width_q;
	logic [ROW_W-1:0]  frame_height_q;
	logic              cfg_write;
	reg_idx_t          reg_sel;

	logic              push;
	item_t             push_item;
	logic              pop;
	logic              head_valid;
	item_t             head_item;
	logic [QCNT_W-1:0] q_count;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_sel   = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[ROW_W-1:0];
				default:          frame_width_q  <= frame_width_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	mf3_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel        (pixel),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.q_count      (q_count),
		.push         (push),
		.push_item    (push_item)
	);

	mf3_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.count      (q_count)
	);

	mf3_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_item    (head_item),
		.pop          (pop),
		.median       (median),
		.center_col   (center_col),
		.center_row   (center_row),
		.frame_last   (frame_last),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QDEPTH))
		else $error("queue count beyond its depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(q_count == QCNT_W'(QDEPTH)) |-> pixel_stall)
		else $error("pixel transfer possible with a full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (center_col != '0) && (center_row != '0))
		else $error("result on a border pixel");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && q_count == QCNT_W'(QDEPTH)) |-> pop)
		else $error("queue written while full");

endmodule
